// ===== sv/sss_pkg.sv =====
// Shared types and constants for the sorted sample statistics block.
// No dependencies; sss_cell and the top level import it.
package sss_pkg;

  localparam int SAMPLE_W = 32;
  localparam int COUNT_OUT_W = 11;
  localparam int PERCENT_W = 7;
  localparam logic [PERCENT_W-1:0] PERCENT_RESET = 7'd50;

  // Division by 100 for the interval length: floor(x / 100) equals
  // (x * LEN_RECIP) >> LEN_SHIFT for every x below 2^28.
  localparam int LEN_SHIFT = 32;
  localparam logic [25:0] LEN_RECIP = 26'd42949673;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_ZERO     = 2'd2,
    ST_TOO_FEW  = 2'd3
  } status_t;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_EVAL = 1'b1
  } opcode_t;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_LEN    = 9'b000000010,
    S_PASS1  = 9'b000000100,
    S_DIVM   = 9'b000001000,
    S_PASS2  = 9'b000010000,
    S_DRAIN  = 9'b000100000,
    S_VSTART = 9'b001000000,
    S_DIVV   = 9'b010000000,
    S_SQRT   = 9'b100000000
  } seq_state_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic                ins;
    logic                rot;
    logic [SAMPLE_W-1:0] smp;
  } cell_ctrl_t;

endpackage

// ===== sv/sss_cell.sv =====
// One storage cell of the sorted chain.
// Depends on sss_pkg for the broadcast control struct.
module sss_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  sss_pkg::cell_ctrl_t            ctrl,
  input  logic [sss_pkg::SAMPLE_W-1:0]   left_val,
  input  logic                           left_ge,
  input  logic                           left_valid,
  input  logic [sss_pkg::SAMPLE_W-1:0]   right_val,
  output logic [sss_pkg::SAMPLE_W-1:0]   val,
  output logic                           ge,
  output logic                           valid
);
  import sss_pkg::*;

  // Holds a value at or above the incoming sample, so the sample goes at or before here.
  assign ge = valid && (val >= ctrl.smp);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (left_ge) begin
        val <= left_val;
      end else if (ge || !valid) begin
        val <= ctrl.smp;
      end
    end else if (ctrl.rot) begin
      val <= right_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.ins) begin
      valid <= left_valid;
    end
  end

endmodule

// ===== sv/sss_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Standalone; used by the top level for the mean and the variance.
module sss_div #(
  parameter int NUM_W = 75,
  parameter int DEN_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dreg;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             take;

  assign trial = {rem, quo[NUM_W-1]};
  assign take  = trial >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dreg <= den;
      quo  <= num;
    end else if (busy) begin
      rem <= take ? DEN_W'(trial - {1'b0, dreg}) : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], take};
    end
  end

endmodule

// ===== sv/sss_sqrt.sv =====
// Bit-serial integer square root of a 64-bit value, two radicand bits per cycle.
// Standalone; used by the top level for the standard deviation.
module sss_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x_in,
  output logic        done,
  output logic [31:0] root
);
  logic [63:0] x;
  logic [63:0] res;
  logic [63:0] bitv;
  logic        busy;
  logic [64:0] trial;

  assign trial = {1'b0, res} + {1'b0, bitv};
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitv == 64'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= x_in;
      res  <= '0;
      bitv <= 64'd1 << 62;
    end else if (busy) begin
      if ({1'b0, x} >= trial) begin
        x   <= x - trial[63:0];
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

// ===== sv/sorted_sample_statistics.sv =====
// Sorted sample statistics: top level with the cell chain and evaluation sequencer.
// Depends on sss_pkg, sss_cell, sss_div and sss_sqrt.
//
// Samples live in a chain of CAPACITY cells kept in ascending order. An add
// transaction inserts its sample at its accepting edge: every cell compares
// against the sample and shifts right where needed, so adds go back to back at
// one per cycle while the result side keeps up. An evaluate transaction runs a
// sequencer: the interval length (a reciprocal multiply for the division by
// 100, then the clamped indices), a full rotation of the chain that sums the
// samples and picks the median, extreme and interval samples, the mean divide,
// a second rotation that accumulates squared deviations, a drain state, a
// state that starts the variance divide, and the square root. An evaluate with
// fewer than two samples is answered at its accepting edge. A new transaction
// is taken only while the sequencer is idle and the result register is empty
// or being read in the same cycle.
// The interval_percent register is always ready and must only be written while
// the block is idle.
module sorted_sample_statistics #(
  parameter int CAPACITY = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sss_pkg::PERCENT_W-1:0]       interval_percent,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic                                opcode,
  input  logic [sss_pkg::SAMPLE_W-1:0]        sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [1:0]                          status,
  output logic [sss_pkg::COUNT_OUT_W-1:0]     sample_count,
  output logic [sss_pkg::SAMPLE_W-1:0]        mean_value,
  output logic [sss_pkg::SAMPLE_W-1:0]        std_deviation,
  output logic [sss_pkg::SAMPLE_W-1:0]        median_value,
  output logic [sss_pkg::SAMPLE_W-1:0]        smallest,
  output logic [sss_pkg::SAMPLE_W-1:0]        largest,
  output logic [sss_pkg::SAMPLE_W-1:0]        interval_low,
  output logic [sss_pkg::SAMPLE_W-1:0]        interval_high
);
  import sss_pkg::*;

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int DEN_W = CW;
  localparam int NUM_W = 2 * SAMPLE_W + CW;
  localparam int LX_W  = PERCENT_W + CW;

  // Configuration register.
  logic [PERCENT_W-1:0] pct;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      pct <= PERCENT_RESET;
    end else if (cfg_valid) begin
      pct <= interval_percent;
    end
  end

  seq_state_t state;
  logic [CW-1:0] count;
  logic          take_item;
  logic          out_free;
  logic          eval_start;

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = !(state == S_IDLE && out_free);
  assign take_item  = item_valid && !item_stall;
  assign eval_start = take_item && opcode == OP_EVAL && count >= CW'(2);

  logic do_ins;
  assign do_ins = take_item && opcode == OP_ADD && sample != '0 &&
                  count != CW'(CAPACITY);

  // Cell chain.
  cell_ctrl_t            ctrl;
  logic [SAMPLE_W-1:0]   cval [CAPACITY];
  logic                  cge  [CAPACITY];
  logic                  cvld [CAPACITY];

  assign ctrl.ins = do_ins;
  assign ctrl.rot = (state == S_PASS1) || (state == S_PASS2);
  assign ctrl.smp = sample;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [SAMPLE_W-1:0] lv;
    logic                lg;
    logic                lvd;
    if (i == 0) begin : g_head
      assign lv  = '0;
      assign lg  = 1'b0;
      assign lvd = 1'b1;
    end else begin : g_body
      assign lv  = cval[i-1];
      assign lg  = cge[i-1];
      assign lvd = cvld[i-1];
    end
    sss_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .left_val   (lv),
      .left_ge    (lg),
      .left_valid (lvd),
      .right_val  (cval[(i + 1) % CAPACITY]),
      .val        (cval[i]),
      .ge         (cge[i]),
      .valid      (cvld[i])
    );
  end

  // Shared divider.
  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;

  sss_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  logic        sq_start;
  logic        sq_done;
  logic [31:0] sq_root;
  logic [63:0] var_val;

  sss_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .x_in  (var_val),
    .done  (sq_done),
    .root  (sq_root)
  );

  // Sequencer datapath registers.
  logic [CW-1:0]            k;
  logic [SAMPLE_W+CW-1:0]   sum;
  logic [NUM_W-1:0]         acc;
  logic [SAMPLE_W-1:0]      mean;
  logic [CW-1:0]            lo_idx;
  logic [CW-1:0]            hi_idx;
  logic [SAMPLE_W-1:0]      v_min, v_max, v_ma, v_mb, v_lo, v_hi;
  logic [63:0]              sqr;
  logic                     sqr_vld;
  logic [SAMPLE_W-1:0]      head;
  logic                     in_range;
  logic                     last_k;
  logic [SAMPLE_W-1:0]      diff;
  logic [CW-1:0]            half;

  assign head     = cval[0];
  assign in_range = k < count;
  assign last_k   = k == CW'(CAPACITY - 1);
  assign diff     = (head >= mean) ? head - mean : mean - head;
  assign half     = count >> 1;
  assign var_val  = div_quo[63:0];

  // Interval length round(pct * n / 100), formed as floor((pct * n + 50) / 100).
  // The product is captured at the accepting edge and scaled in S_LEN while
  // len_ready is low; the indices follow once len_ready is set.
  logic [LX_W-1:0]    lx;
  logic [LX_W+25:0]   lprod;
  logic               len_ready;

  assign lprod = lx * LEN_RECIP;

  // Interval indices from the length.
  logic [CW:0]   len;
  logic [CW+1:0] dlo;
  logic [CW+1:0] hsum;
  logic [CW:0]   lo_raw;
  logic [CW:0]   hi_raw;
  logic [CW:0]   nm1;

  assign dlo    = {2'b00, count} - {1'b0, len};
  assign lo_raw = dlo[CW+1] ? '0 : (CW+1)'((dlo + 1'b1) >> 1);
  assign hsum   = {2'b00, count} + {1'b0, len} + 1'b1;
  assign hi_raw = (CW+1)'(hsum >> 1);
  assign nm1    = {1'b0, count} - 1'b1;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if (state == S_PASS1 && last_k) begin
      // The sample at the last position is added to the sum only at this edge,
      // so it is folded into the dividend here.
      div_start = 1'b1;
      div_num   = NUM_W'(sum) + (in_range ? NUM_W'(head) : NUM_W'(0));
      div_den   = DEN_W'(count);
    end else if (state == S_VSTART) begin
      div_start = 1'b1;
      div_num   = acc;
      div_den   = DEN_W'(count);
    end
  end

  assign sq_start = (state == S_DIVV) && div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (eval_start) begin
            state <= S_LEN;
          end
        end
        S_LEN:    if (len_ready) state <= S_PASS1;
        S_PASS1:  if (last_k) state <= S_DIVM;
        S_DIVM:   if (div_done) state <= S_PASS2;
        S_PASS2:  if (last_k) state <= S_DRAIN;
        S_DRAIN:  state <= S_VSTART;
        S_VSTART: state <= S_DIVV;
        S_DIVV:   if (div_done) state <= S_SQRT;
        S_SQRT:   if (sq_done) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_ins) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      sqr_vld   <= 1'b0;
      len_ready <= 1'b0;
    end else begin
      sqr_vld   <= (state == S_PASS2) && in_range;
      len_ready <= (state == S_LEN) && !len_ready;
      if (ctrl.rot) begin
        k <= last_k ? '0 : k + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (eval_start) begin
      lx <= LX_W'(pct * count) + LX_W'(50);
    end
    if (state == S_LEN && !len_ready) begin
      len <= lprod[LEN_SHIFT +: CW+1];
    end
    if (state == S_LEN && len_ready) begin
      lo_idx <= (lo_raw > nm1) ? nm1[CW-1:0] : lo_raw[CW-1:0];
      hi_idx <= (hi_raw > nm1) ? nm1[CW-1:0] : hi_raw[CW-1:0];
      sum    <= '0;
      acc    <= '0;
    end
    if (state == S_PASS1) begin
      if (in_range) begin
        sum <= sum + (SAMPLE_W+CW)'(head);
      end
      if (k == '0)          v_min <= head;
      if (k == nm1[CW-1:0]) v_max <= head;
      if (k == half)        v_ma  <= head;
      if (k == half - 1'b1) v_mb  <= head;
      if (k == lo_idx)      v_lo  <= head;
      if (k == hi_idx)      v_hi  <= head;
    end
    if (state == S_DIVM && div_done) begin
      mean <= div_quo[SAMPLE_W-1:0];
    end
    sqr <= diff * diff;
    if (sqr_vld) begin
      acc <= acc + NUM_W'(sqr);
    end
  end

  // Result register.
  logic [SAMPLE_W:0] msum;
  assign msum = {1'b0, v_ma} + {1'b0, v_mb};

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take_item && !eval_start) begin
      result_valid <= 1'b1;
    end else if (state == S_SQRT && sq_done) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_item && !eval_start) begin
      if (opcode == OP_EVAL) begin
        status <= ST_TOO_FEW;
      end else if (sample == '0) begin
        status <= ST_ZERO;
      end else if (count == CW'(CAPACITY)) begin
        status <= ST_FULL;
      end else begin
        status <= ST_OK;
      end
      sample_count  <= do_ins ? COUNT_OUT_W'(count + 1'b1) : COUNT_OUT_W'(count);
      mean_value    <= '0;
      std_deviation <= '0;
      median_value  <= '0;
      smallest      <= '0;
      largest       <= '0;
      interval_low  <= '0;
      interval_high <= '0;
    end else if (state == S_SQRT && sq_done) begin
      status        <= ST_OK;
      sample_count  <= COUNT_OUT_W'(count);
      mean_value    <= mean;
      std_deviation <= sq_root;
      median_value  <= count[0] ? v_ma : msum[SAMPLE_W:1];
      smallest      <= v_min;
      largest       <= v_max;
      interval_low  <= v_lo;
      interval_high <= v_hi;
    end
  end

endmodule
